// ===== src/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the alphabet lookup for the base64 stream encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int B64E_QUEUE_DEPTH = 2;

   localparam logic [6:0] B64E_PAD_CHAR   = 7'h3D;
   localparam logic [5:0] B64E_SLICE_MASK = 6'h3F;

   // number of real bytes in a group
   localparam logic [1:0] B64E_REAL_ONE   = 2'd1;
   localparam logic [1:0] B64E_REAL_TWO   = 2'd2;
   localparam logic [1:0] B64E_REAL_THREE = 2'd3;

   // one packed group handed from front to back
   typedef struct packed {
      logic [23:0] packed_bits;
      logic [1:0]  real_bytes;
      logic        done;
   } group_type;

   // standard 64-symbol alphabet
   function automatic logic [6:0] b64e_char(input logic [5:0] slice);
      logic [6:0] ch;
      if (slice < 6'd26) begin
         ch = 7'h41 + {1'b0, slice};
      end else if (slice < 6'd52) begin
         ch = 7'h61 + {1'b0, slice} - 7'd26;
      end else if (slice < 6'd62) begin
         ch = 7'h30 + {1'b0, slice} - 7'd52;
      end else if (slice == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

// ===== src/b64e_if.sv =====
// ----------------------------------------------------------------------------
// b64e channel interfaces
// valid/ready channels for message bytes and encoded characters
// ----------------------------------------------------------------------------
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       group_last;
   logic       message_done;

   modport source (output valid, output out_char, output group_last, output message_done,
                   input ready);
   modport sink   (input valid, input out_char, input group_last, input message_done,
                   output ready);
endinterface

// ===== src/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// accepts bytes, holds a partial group and pushes complete or message-ending groups
// ----------------------------------------------------------------------------
module b64e_front (
   input  logic                 clock,
   input  logic                 reset,
   b64e_req_if.sink             req,
   output logic                 push_valid,
   input  logic                 push_ready,
   output b64e_pkg::group_type  push_group
);

   logic [7:0] held_first_ff, held_first_in;
   logic [7:0] held_second_ff, held_second_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      held_first_in          = held_first_ff;
      held_second_in         = held_second_ff;
      count_in               = count_ff;
      push_valid             = 1'b0;
      push_group.packed_bits = {req.data_byte, 16'h0000};
      push_group.real_bytes  = b64e_pkg::B64E_REAL_ONE;
      push_group.done        = req.end_of_message;
      if (count_ff == 2'd2) begin
         push_group.packed_bits = {held_first_ff, held_second_ff, req.data_byte};
         push_group.real_bytes  = b64e_pkg::B64E_REAL_THREE;
      end else if (count_ff == 2'd1) begin
         push_group.packed_bits = {held_first_ff, req.data_byte, 8'h00};
         push_group.real_bytes  = b64e_pkg::B64E_REAL_TWO;
      end
      if (accept) begin
         if (count_ff == 2'd2 || req.end_of_message) begin
            push_valid     = 1'b1;
            held_first_in  = 8'h00;
            held_second_in = 8'h00;
            count_in       = 2'd0;
         end else if (count_ff == 2'd1) begin
            held_second_in = req.data_byte;
            count_in       = 2'd2;
         end else begin
            // fresh group, unused count value included
            held_first_in  = req.data_byte;
            held_second_in = 8'h00;
            count_in       = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_first_ff  <= 8'h00;
         held_second_ff <= 8'h00;
         count_ff       <= 2'd0;
      end else begin
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         count_ff       <= count_in;
      end
   end

endmodule

// ===== src/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// small group queue between front and back
// ----------------------------------------------------------------------------
module b64e_queue #(
   parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  b64e_pkg::group_type  push_group,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output b64e_pkg::group_type  pop_group
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b64e_pkg::group_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_group  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// ===== src/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// turns one group into four characters, one per cycle while rsp is ready, through an output register
// ----------------------------------------------------------------------------
module b64e_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  b64e_pkg::group_type  pop_group,
   b64e_rsp_if.source           rsp
);

   b64e_pkg::group_type group_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff;
   logic       out_last_ff, out_done_ff;
   logic       slot_free, step;
   logic [5:0] slice;
   logic [6:0] next_char;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign step      = busy_ff && slot_free;
   assign pop_ready = !busy_ff || (step && idx_ff == 2'd3);

   always_comb begin
      unique case (idx_ff)
         2'd0: slice = group_ff.packed_bits[23:18];
         2'd1: slice = group_ff.packed_bits[17:12];
         2'd2: slice = group_ff.packed_bits[11:6];
         2'd3: slice = group_ff.packed_bits[5:0] & b64e_pkg::B64E_SLICE_MASK;
      endcase
      next_char = (idx_ff > group_ff.real_bytes) ? b64e_pkg::B64E_PAD_CHAR
                                                 : b64e_pkg::b64e_char(slice);
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (step) begin
         out_valid_in = 1'b1;
         idx_in       = idx_ff + 1'b1;
         if (idx_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         group_ff <= pop_group;
      end
      if (step) begin
         out_char_ff <= next_char;
         out_last_ff <= (idx_ff == 2'd3);
         out_done_ff <= (idx_ff == 2'd3) && group_ff.done;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.out_char     = out_char_ff;
   assign rsp.group_last   = out_last_ff;
   assign rsp.message_done = out_done_ff;

endmodule

// ===== src/base64_stream_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// base64 encoder (standard alphabet, with padding) for a byte stream
// ----------------------------------------------------------------------------
// Bytes enter one item per cycle on req while the queue has room, the last
// byte of a message flagged by end_of_message. Every third byte, or the flagged
// byte, closes a group; the group is packed into 24 bits, first byte high, and
// four ASCII characters leave on rsp, one item per cycle while rsp is ready,
// high 6-bit slice first. A short final group is zero-filled and its last one
// or two characters are '='. group_last marks the fourth character of each
// group, message_done the last character of a message. The front accepts a byte
// every cycle while the group queue has room; the back drains one character per
// cycle into an output register while rsp is ready, so the single rsp port sets
// the sustained rate at four characters per three bytes. Each group passes the
// queue, group and output registers. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit #(
   parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req,
   b64e_rsp_if.source  rsp
);

   // front to queue
   logic                 push_valid;
   logic                 push_ready;
   b64e_pkg::group_type  push_group;

   // queue to back
   logic                 pop_valid;
   logic                 pop_ready;
   b64e_pkg::group_type  pop_group;

   // byte intake and group assembly
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group)
   );

   // decoupling queue of complete groups
   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group)
   );

   // character generation
   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_group (pop_group),
      .rsp       (rsp)
   );

   // the front never closes a group the queue cannot take
   a_push_fits : assert property (@(posedge clock) disable iff (reset)
      !(push_valid && !push_ready))
      else $error("group pushed into a full queue");

   // end of message only on the fourth character of a group
   a_done_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.message_done |-> rsp.group_last)
      else $error("message_done without group_last");

   // a pad on the third character is followed by a pad on the fourth
   a_pad_pair : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.group_last && rsp.out_char == b64e_pkg::B64E_PAD_CHAR
      |=> rsp.valid && rsp.out_char == b64e_pkg::B64E_PAD_CHAR)
      else $error("pad character not followed by pad");

endmodule

// ===== tb/sv/base64_stream_encoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit_test
// self-checking bench for the base64 stream encoder: a directed table of
// message bytes, then random messages with random idling on both channels and
// one long output stall; every character is compared with a local encoder,
// or with the table's characters on typed rows
module base64_stream_encoder_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 400;
   localparam int MAX_REPORTS  = 10;
   localparam int LONG_HOLD    = 300;   // receiver stall, in cycles
   localparam int HOLD_AFTER   = 60;    // characters seen before the long stall
   localparam int TAIL_CYCLES  = 16;    // settle time after the last character

   // idle draw per side
   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;

   // alphabet, first symbol in the top byte
   localparam logic [8*64-1:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // one encoded character as it leaves on rsp
   typedef struct packed {
      logic [6:0] out_char;
      logic       group_last;
      logic       message_done;
   } char_item_type;

   // one directed row; typed rows carry the four characters they close
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        end_of_message;
      logic        typed;
      logic [31:0] chars;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   b64e_req_if req_ch ();
   b64e_rsp_if rsp_ch ();

   base64_stream_encoder_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #10 clock = ~clock;

   // local copy of the encoder state
   logic [7:0] pend_first;
   logic [7:0] pend_second;
   logic [1:0] pend_count;

   char_item_type expected_chars[$];
   stim_row_type  directed_rows[$];

   int fail_count  = 0;
   int chars_seen  = 0;
   int rush_left[2] = '{0, 0};

   // ---------------------------------------------------------------------------
   // local encoder: advances the group state by one byte and returns the
   // characters that byte closes (zero or four)
   // ---------------------------------------------------------------------------
   function automatic int encode_byte(input logic [7:0] b, input logic eom,
                                      output char_item_type group[4]);
      logic [23:0] bits;
      logic [5:0]  slice;
      int          real_n;
      int          n;
      n      = 0;
      bits   = '0;
      real_n = 0;
      if (pend_count == 2'd2) begin
         // third byte always closes the group
         bits   = {pend_first, pend_second, b};
         real_n = 3;
         n      = 4;
      end else if (pend_count == 2'd1 && eom) begin
         bits   = {pend_first, b, 8'h00};
         real_n = 2;
         n      = 4;
      end else if (pend_count == 2'd1) begin
         pend_second = b;
         pend_count  = 2'd2;
      end else if (eom) begin
         // count 0 (or the unused 3) starts a fresh group
         bits   = {b, 16'h0000};
         real_n = 1;
         n      = 4;
      end else begin
         pend_first  = b;
         pend_second = 8'h00;
         pend_count  = 2'd1;
      end
      for (int k = 0; k < 4; k++) begin
         slice = bits[23 - 6*k -: 6];
         if (k > real_n) group[k].out_char = b64e_pkg::B64E_PAD_CHAR;
         else group[k].out_char = SYMBOLS[8*(63 - int'(slice)) +: 7];
         group[k].group_last   = (k == 3);
         group[k].message_done = (k == 3) && eom;
      end
      if (n == 4) begin
         pend_first  = 8'h00;
         pend_second = 8'h00;
         pend_count  = 2'd0;
      end
      return n;
   endfunction

   // idle cycles before the next item on one side, with runs of no idling
   function automatic int draw_idle(input int side);
      int n;
      n = 0;
      if (rush_left[side] > 0) begin
         rush_left[side]--;
      end else if ($urandom_range(0, 19) == 0) begin
         rush_left[side] = $urandom_range(8, 24);
      end else begin
         n = $urandom_range(0, 6);
      end
      return n;
   endfunction

   function automatic void note_failure(input string what, input char_item_type want,
                                        input char_item_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch (%s): expected char %h last %b done %b, got char %h last %b done %b",
                  what, want.out_char, want.group_last, want.message_done,
                  got.out_char, got.group_last, got.message_done);
      end
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic eom, input logic typed,
                                   input logic [31:0] chars);
      stim_row_type r;
      r.data_byte      = b;
      r.end_of_message = eom;
      r.typed          = typed;
      r.chars          = chars;
      directed_rows.push_back(r);
   endfunction

   // ---------------------------------------------------------------------------
   // offer one byte: called and returning at a falling edge; the expected
   // characters are queued at the edge that accepts the item
   // ---------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic eom, input logic typed,
                            input logic [31:0] chars);
      int            gap;
      int            n;
      char_item_type group[4];
      gap = draw_idle(SIDE_REQ);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.data_byte      <= b;
      req_ch.end_of_message <= eom;
      req_ch.valid          <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n = encode_byte(b, eom, group);
      for (int k = 0; k < n; k++) begin
         // typed rows take the characters straight from the table
         if (typed) group[k].out_char = chars[30 - 8*k -: 7];
         expected_chars.push_back(group[k]);
      end
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // directed table: short groups of each size, alphabet extremes, a message
   // that ends on a full group, and a group closed without ending the message
   // ---------------------------------------------------------------------------
   task automatic fill_directed_rows();
      add_row(8'h4D, 1'b0, 1'b0, 32'h0);
      add_row(8'h61, 1'b0, 1'b0, 32'h0);
      add_row(8'h6E, 1'b0, 1'b1, "TWFu");   // full group, message goes on
      add_row(8'h00, 1'b1, 1'b1, "AA==");   // one-byte tail ends the message, two pads
      add_row(8'hFF, 1'b0, 1'b0, 32'h0);
      add_row(8'hFF, 1'b1, 1'b1, "//8=");   // two-byte tail, one pad
      add_row(8'hFF, 1'b0, 1'b0, 32'h0);
      add_row(8'hFF, 1'b0, 1'b0, 32'h0);
      add_row(8'hFF, 1'b1, 1'b1, "////");   // message ends on a full group
      add_row(8'h00, 1'b0, 1'b0, 32'h0);
      add_row(8'h00, 1'b0, 1'b0, 32'h0);
      add_row(8'h00, 1'b0, 1'b1, "AAAA");
      add_row(8'h4D, 1'b1, 1'b1, "TQ==");
      add_row(8'h4D, 1'b0, 1'b0, 32'h0);
      add_row(8'h61, 1'b1, 1'b1, "TWE=");
      add_row(8'hFB, 1'b0, 1'b0, 32'h0);    // plus slices
      add_row(8'hEF, 1'b0, 1'b0, 32'h0);
      add_row(8'hBE, 1'b1, 1'b0, 32'h0);
      add_row(8'h80, 1'b0, 1'b0, 32'h0);
      add_row(8'h01, 1'b1, 1'b0, 32'h0);
      add_row(8'h7F, 1'b0, 1'b0, 32'h0);    // group closes, tail of one follows
      add_row(8'hFE, 1'b0, 1'b0, 32'h0);
      add_row(8'h03, 1'b0, 1'b0, 32'h0);
      add_row(8'h55, 1'b1, 1'b0, 32'h0);
   endtask

   // ---------------------------------------------------------------------------
   // receiver: random ready, one long stall once the flow is going, and a
   // field by field compare of every accepted character
   // ---------------------------------------------------------------------------
   initial begin : drain_chars
      int            hold;
      bit            stalled;
      char_item_type got;
      char_item_type want;
      stalled = 1'b0;
      wait (reset === 1'b0);
      forever begin
         hold = draw_idle(SIDE_RSP);
         if (!stalled && chars_seen >= HOLD_AFTER) begin
            // input side keeps offering bytes and backs up into the block
            hold    = LONG_HOLD;
            stalled = 1'b1;
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         got.out_char     = rsp_ch.out_char;
         got.group_last   = rsp_ch.group_last;
         got.message_done = rsp_ch.message_done;
         if (expected_chars.size() == 0) begin
            note_failure("unexpected character", '0, got);
         end else begin
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.group_last !== want.group_last ||
                got.message_done !== want.message_done) begin
               note_failure("wrong character", want, got);
            end
         end
         chars_seen++;
         @(negedge clock);
      end
   end

   // run limit, well past the slowest legal run
   initial begin : run_limit
      #(5_000_000);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // main sequence: reset, directed table, random messages, drain, verdict
   // ---------------------------------------------------------------------------
   initial begin : main_flow
      int           sent;
      int           len;
      logic [7:0]   b;
      stim_row_type r;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = 8'h00;
      req_ch.end_of_message = 1'b0;
      rsp_ch.ready          = 1'b0;
      pend_first            = 8'h00;
      pend_second           = 8'h00;
      pend_count            = 2'd0;
      fill_directed_rows();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_byte(r.data_byte, r.end_of_message, r.typed, r.chars);
      end

      // random messages, mostly short, a few long ones
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) len = $urandom_range(9, 40);
         else len = $urandom_range(1, 8);
         for (int j = 0; j < len; j++) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, (j == len - 1), 1'b0, 32'h0);
            sent++;
         end
      end
      req_ch.valid <= 1'b0;

      // wait for every queued character, then watch for stray ones
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_chars.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== base64_stream_encoder_unit.f =====
src/b64e_pkg.sv
src/b64e_if.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder_unit.sv
tb/sv/base64_stream_encoder_unit_test.sv
